// ===== sv/cetr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cetr_pkg;

    // Every expander module has eight inputs, one lane each.
    localparam int LANES       = 8;
    localparam int LANE_W      = 3;
    localparam int MOD_W       = 3;
    localparam int NUM_W       = 8;
    localparam int CNT_W       = 4;
    localparam int OFS_W       = 3;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_MODULE_COUNT   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_CONTACT_OFFSET = 1'b1;

    localparam logic [CNT_W-1:0] MODULE_COUNT_RESET   = 4'd1;
    localparam logic [OFS_W-1:0] CONTACT_OFFSET_RESET = 3'd0;

    typedef struct packed {
        logic [NUM_W-1:0] number;
        logic             state;
    } t_event;

endpackage

`default_nettype wire

// ===== sv/cetr_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cetr_lane #(
    parameter int LANE_INDEX = 0
) (
    input  wire logic                     i_level,
    input  wire logic                     i_prev,
    input  wire logic                     i_status,
    input  wire logic [cetr_pkg::NUM_W-1:0] i_base,
    output logic                          o_rising,
    output logic                          o_new_status,
    output cetr_pkg::t_event              o_event
);
    import cetr_pkg::*;

    always_comb begin
        o_rising       = i_level & ~i_prev;
        o_new_status   = i_status ^ o_rising;
        o_event.number = i_base + NUM_W'(LANE_INDEX);
        o_event.state  = o_new_status;
    end

endmodule

`default_nettype wire

// ===== sv/cetr_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cetr_merge (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_load,
    input  wire logic [cetr_pkg::LANES-1:0] i_rising,
    input  cetr_pkg::t_event               i_event [cetr_pkg::LANES],
    output logic                           o_can_load,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output cetr_pkg::t_event               o_event,
    output logic                           o_last
);
    import cetr_pkg::*;

    logic [LANES-1:0]  r_mask;
    logic [LANES-1:0]  n_mask;
    t_event            r_evt [LANES];
    logic              r_ovalid;
    t_event            r_oevt;
    logic              r_olast;

    logic [LANE_W-1:0] sel;
    logic [LANES-1:0]  rest;
    logic              single;
    logic              move;

    always_comb begin
        sel = '0;
        for (int i = LANES - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                sel = LANE_W'(i);
            end
        end
        // Clearing the lowest set bit leaves the events still to send.
        rest       = r_mask & (r_mask - LANES'(1));
        single     = (rest == '0);
        move       = (r_mask != '0) && (!r_ovalid || i_ready);
        o_can_load = (r_mask == '0) || (move && single);
        if (i_load) begin
            n_mask = i_rising;
        end else if (move) begin
            n_mask = rest;
        end else begin
            n_mask = r_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (move) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_evt <= i_event;
        end
        if (move) begin
            r_oevt  <= r_evt[sel];
            r_olast <= single;
        end
    end

    assign o_valid = r_ovalid;
    assign o_event = r_oevt;
    assign o_last  = r_olast;

endmodule

`default_nettype wire

// ===== sv/contact_edge_toggle_reporter.sv =====
// A read that toggles loads the event stage, which feeds the output register.
// Throughput: one event per cycle while the receiver is ready; a read holds the event
// stage until its last event moves to the output register, and in that cycle the next
// read is taken. Reads with no toggle skip it. Eight lanes evaluate all bits at once.
// Reset (synchronous, active low) clears all status bits, presets levels to ones and
// loads module_count = 1, contact_offset = 0.
`timescale 1ns / 1ps
`default_nettype none

module contact_edge_toggle_reporter #(
    parameter int MAX_MODULES = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [cetr_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [cetr_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [2:0] module_index, [10:3] port_byte, [15:11] zero
    input  wire logic [15:0]                    i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // [7:0] contact_number, [8] new_state, [15:9] zero
    output logic [15:0]                         o_m_axis_tdata,
    output logic                                o_m_axis_tlast
);
    import cetr_pkg::*;

    localparam int DEPTH = (MAX_MODULES < 8) ? MAX_MODULES : 8;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CNT_W:0] MAX_M = (CNT_W+1)'(MAX_MODULES);

    logic [CNT_W-1:0] r_module_count;
    logic [OFS_W-1:0] r_contact_offset;
    logic [LANES-1:0] r_prev [DEPTH];
    logic [LANES-1:0] r_stat [DEPTH];

    logic [MOD_W-1:0] in_mod;
    logic [LANES-1:0] levels;
    logic [IDX_W-1:0] idx;
    logic             mod_ok;
    logic             accept;
    logic [NUM_W-1:0] base;
    logic [LANES-1:0] prev_row;
    logic [LANES-1:0] stat_row;
    logic [LANES-1:0] rising;
    logic [LANES-1:0] new_status;
    t_event           lane_evt [LANES];
    logic             can_load;
    t_event           out_evt;

    always_comb begin
        in_mod = i_s_axis_tdata[MOD_W-1:0];
        levels = ~i_s_axis_tdata[MOD_W +: LANES];
        idx    = IDX_W'(in_mod);
        mod_ok = ((CNT_W+1)'(in_mod) < (CNT_W+1)'(r_module_count))
              && ((CNT_W+1)'(in_mod) < MAX_M);
        accept = i_s_axis_tvalid && can_load;
        base   = {1'b0, r_contact_offset, 4'b0000} + {2'b00, in_mod, 3'b000} + NUM_W'(1);
        if (mod_ok) begin
            prev_row = r_prev[idx];
            stat_row = r_stat[idx];
        end else begin
            prev_row = '1;
            stat_row = '0;
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        cetr_lane #(
            .LANE_INDEX(g)
        ) u_lane (
            .i_level     (levels[g]),
            .i_prev      (prev_row[g]),
            .i_status    (stat_row[g]),
            .i_base      (base),
            .o_rising    (rising[g]),
            .o_new_status(new_status[g]),
            .o_event     (lane_evt[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_module_count   <= MODULE_COUNT_RESET;
            r_contact_offset <= CONTACT_OFFSET_RESET;
            for (int m = 0; m < DEPTH; m++) begin
                r_prev[m] <= '1;
                r_stat[m] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_MODULE_COUNT:   r_module_count   <= i_cfg_wdata[CNT_W-1:0];
                    REG_CONTACT_OFFSET: r_contact_offset <= i_cfg_wdata[OFS_W-1:0];
                    default: ;
                endcase
            end
            if (accept && mod_ok) begin
                r_prev[idx] <= levels;
                r_stat[idx] <= new_status;
            end
        end
    end

    cetr_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (accept && mod_ok && (rising != '0)),
        .i_rising  (rising),
        .i_event   (lane_evt),
        .o_can_load(can_load),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_event   (out_evt),
        .o_last    (o_m_axis_tlast)
    );

    assign o_s_axis_tready = can_load;
    assign o_m_axis_tdata  = {7'b0000000, out_evt.state, out_evt.number};

endmodule

`default_nettype wire

// ===== tb/tb_contact_edge_toggle_reporter.sv =====
`timescale 1ns / 1ps

module tb_contact_edge_toggle_reporter;
    import cetr_pkg::*;

    localparam int MODS        = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [MOD_W-1:0] module_idx;
        logic [7:0]       raw;
    } t_read;

    typedef struct packed {
        logic [NUM_W-1:0] number;
        logic             state;
        logic             last;
    } t_toggle;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic [15:0]           s_data    = '0;
    logic                  m_ready   = 1'b1;
    wire                   s_ready;
    wire                   m_valid;
    wire  [15:0]           m_data;
    wire                   m_last;

    contact_edge_toggle_reporter #(
        .MAX_MODULES(MODS)
    ) DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_addr     (cfg_addr),
        .i_cfg_wdata    (cfg_wdata),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tlast (m_last)
    );

    // Shadow of the block: configuration and per-module levels and status.
    logic [CNT_W-1:0] count_cfg;
    logic [OFS_W-1:0] offset_cfg;
    logic [7:0]       level_mem  [MODS];
    logic [7:0]       status_mem [MODS];
    logic [7:0]       raw_shadow [MODS];

    t_read   read_q[$];
    t_toggle toggle_q[$];

    int n_queued  = 0;
    int n_reads   = 0;
    int n_ignored = 0;
    int n_events  = 0;
    int errors    = 0;
    int cycles    = 0;
    int src_idle  = 0;
    int sink_idle = 0;
    int hold_left = 0;

    logic hold_go   = 1'b0;
    logic hold_done = 1'b0;
    logic calm      = 1'b0;

    t_read   drv_item;
    t_read   seen_read;
    t_toggle want_ev;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic void predict_toggles(input t_read rd);
        logic [7:0] active;
        logic [7:0] rising;
        t_toggle    ev;
        active = ~rd.raw;
        if (rd.module_idx >= count_cfg) begin
            n_ignored++;
            return;
        end
        rising = active & ~level_mem[rd.module_idx];
        level_mem[rd.module_idx] = active;
        status_mem[rd.module_idx] = status_mem[rd.module_idx] ^ rising;
        for (int b = 0; b < 8; b++) begin
            if (rising[b]) begin
                ev.number = NUM_W'(16 * offset_cfg + rd.module_idx * 8 + b + 1);
                ev.state  = status_mem[rd.module_idx][b];
                ev.last   = ((rising >> (b + 1)) == 8'd0);
                toggle_q.push_back(ev);
            end
        end
    endfunction

    // Mostly reads from modules in use, with a few bits pressed or released since
    // the previous read of the same module, so that edges come often.
    function automatic t_read random_read(input int cnt);
        t_read      rd;
        int         live;
        int         pick;
        logic [7:0] mask;
        live = (cnt > MODS) ? MODS : cnt;
        if (live > 0 && $urandom_range(0, 9) < 8)
            rd.module_idx = MOD_W'($urandom_range(0, live - 1));
        else
            rd.module_idx = MOD_W'($urandom_range(0, MODS - 1));
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            mask = 8'(1 << $urandom_range(0, 7));
            if ($urandom_range(0, 1) == 1)
                mask = mask | 8'(1 << $urandom_range(0, 7));
            rd.raw = raw_shadow[rd.module_idx] ^ mask;
        end else if (pick == 5) begin
            rd.raw = 8'h00;
        end else if (pick == 6) begin
            rd.raw = 8'hFF;
        end else begin
            rd.raw = 8'($urandom);
        end
        raw_shadow[rd.module_idx] = rd.raw;
        return rd;
    endfunction

    task automatic queue_read(input int idx, input logic [7:0] raw);
        t_read rd;
        rd.module_idx = MOD_W'(idx);
        rd.raw        = raw;
        read_q.push_back(rd);
        n_queued++;
    endtask

    task automatic wait_drained();
        while (n_reads != n_queued || toggle_q.size() != 0)
            @(posedge clk);
        // Reads that toggle nothing may still be passing through.
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        if (addr == REG_MODULE_COUNT)
            count_cfg = value[CNT_W-1:0];
        else
            offset_cfg = value[OFS_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Sender: offers queued reads, with random gaps.
    always @(posedge clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (src_idle > 0) begin
                src_idle--;
                s_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                src_idle = $urandom_range(0, 4);
                s_valid <= 1'b0;
            end else if (read_q.size() > 0) begin
                drv_item = read_q.pop_front();
                s_valid <= 1'b1;
                s_data  <= {5'b0, drv_item.raw, drv_item.module_idx};
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Every accepted read is counted; reads on modules in use update the shadow state.
    always @(posedge clk) begin
        if (rst_n && s_valid && s_ready) begin
            seen_read.module_idx = s_data[2:0];
            seen_read.raw        = s_data[10:3];
            predict_toggles(seen_read);
            n_reads++;
        end
    end

    // Receiver: random stalls, and one long hold-off so the block backs up.
    always @(posedge clk) begin
        if (!rst_n) begin
            m_ready <= 1'b1;
        end else if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (calm) begin
            m_ready <= 1'b1;
        end else if (sink_idle > 0) begin
            sink_idle--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            sink_idle = $urandom_range(0, 4);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) begin
            n_events++;
            if (toggle_q.size() == 0) begin
                $error("unexpected event: contact_number %0d new_state %0d",
                       m_data[7:0], m_data[8]);
                errors++;
            end else begin
                want_ev = toggle_q.pop_front();
                if (m_data[7:0] !== want_ev.number) begin
                    $error("contact_number: expected %0d, actual %0d",
                           want_ev.number, m_data[7:0]);
                    errors++;
                end
                if (m_data[8] !== want_ev.state) begin
                    $error("new_state: expected %0d, actual %0d", want_ev.state, m_data[8]);
                    errors++;
                end
                if (m_last !== want_ev.last) begin
                    $error("last_event: expected %0d, actual %0d", want_ev.last, m_last);
                    errors++;
                end
                if (m_data[15:9] !== 7'd0) begin
                    $error("padding: expected 0, actual %0h", m_data[15:9]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int phase_count  [6];
        int phase_offset [6];
        count_cfg  = MODULE_COUNT_RESET;
        offset_cfg = CONTACT_OFFSET_RESET;
        for (int m = 0; m < MODS; m++) begin
            level_mem[m]  = 8'hFF;
            status_mem[m] = 8'h00;
            raw_shadow[m] = 8'hFF;
        end
        phase_count  = '{15, 8, 3, 1, 8, 6};
        // Bit 3 of an offset write is dropped by the block.
        phase_offset = '{11, 4, 6, 0, 7, 2};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: only module 0 is in use.
        queue_read(0, 8'h00);
        queue_read(0, 8'h00);
        queue_read(0, 8'hFF);
        queue_read(0, 8'h00);
        queue_read(1, 8'h00);
        queue_read(7, 8'h55);
        queue_read(0, 8'hFE);
        queue_read(0, 8'hFF);
        queue_read(0, 8'hFE);
        queue_read(0, 8'h7F);
        queue_read(0, 8'hAA);
        wait_drained();

        // Largest contact numbers.
        write_reg(REG_MODULE_COUNT, 4'd8);
        write_reg(REG_CONTACT_OFFSET, 4'd7);
        queue_read(7, 8'h00);
        queue_read(7, 8'hFF);
        queue_read(3, 8'h5A);
        queue_read(0, 8'h00);
        queue_read(6, 8'h7F);
        wait_drained();

        // A module count of zero ignores every read.
        write_reg(REG_MODULE_COUNT, 4'd0);
        queue_read(0, 8'hFF);
        queue_read(0, 8'h00);
        queue_read(3, 8'h00);
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            write_reg(REG_MODULE_COUNT, CFG_DATA_W'(phase_count[p]));
            write_reg(REG_CONTACT_OFFSET, CFG_DATA_W'(phase_offset[p]));
            if (p == 1) begin
                // Full presses on modules 0 to 5 while the receiver holds off.
                for (int i = 0; i < 12; i++)
                    queue_read((i / 2) % MODS, (i % 2 == 0) ? 8'hFF : 8'h00);
                hold_go <= 1'b1;
            end
            if (p == 5)
                calm <= 1'b1;
            for (int i = 0; i < 46; i++)
                read_q.push_back(random_read(count_cfg));
            n_queued += 46;
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (toggle_q.size() != 0) begin
            $error("%0d expected events never arrived", toggle_q.size());
            errors++;
        end
        $display("Run covered %0d port reads (%0d on unused modules) and %0d toggle events,",
                 n_reads, n_ignored, n_events);
        $display("over nine register settings including zero and full module counts.");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== contact_edge_toggle_reporter.f =====
sv/cetr_pkg.sv
sv/cetr_lane.sv
sv/cetr_merge.sv
sv/contact_edge_toggle_reporter.sv
tb/tb_contact_edge_toggle_reporter.sv
